[design/cqsr_pkg.sv]
package cqsr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int FUNC_W      = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CAP_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(QUEUE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH,
    FUNC_POP,
    FUNC_CONTAINS,
    FUNC_REMOVE
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_POP_DATA,
    ST_HEAD_RD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [PTR_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [PTR_W-1:0]       raddr;
  } ram_req_t;

  typedef struct packed {
    logic                   status;
    logic [VALUE_WIDTH-1:0] popped_value;
    logic                   found;
    logic [CAP_W-1:0]       count;
    logic                   full_res;
    logic [VALUE_WIDTH-1:0] head_value;
  } res_t;

  // Advance a ring pointer, wrapping at the capacity in use.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= c) ? '0 : n[PTR_W-1:0];
  endfunction

  // Step a ring pointer back, wrapping to the last slot in use.
  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] t;
    t = c - CAP_W'(1);
    return (p == '0) ? t[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

  // Bring a written capacity into the range one to the depth.
  function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] d);
    logic [CAP_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = CAP_W'(1);
    end else if (d > CAP_W'(QUEUE_DEPTH)) begin
      r = CAP_W'(QUEUE_DEPTH);
    end
    return r;
  endfunction

endpackage

[design/cqsr_req_if.sv]
interface cqsr_req_if;
  logic                             valid;
  logic                             ready;
  logic [cqsr_pkg::FUNC_W-1:0]      func;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

[design/cqsr_rsp_if.sv]
interface cqsr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] popped_value;
  logic                             found;
  logic [cqsr_pkg::CAP_W-1:0]       count;
  logic                             full_res;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] head_value;

  modport source (output valid, status, popped_value, found, count, full_res, head_value,
                  input ready);
  modport sink (input valid, status, popped_value, found, count, full_res, head_value,
                output ready);
endinterface

[design/cqsr_cfg_if.sv]
interface cqsr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cqsr_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/cqsr_ram.sv]
module cqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cqsr_ctrl.sv]
module cqsr_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  cqsr_req_if.sink                         req,
  cqsr_cfg_if.sink                         cfg,
  input  logic [cqsr_pkg::VALUE_WIDTH-1:0] rdata,
  output cqsr_pkg::ram_req_t               ram_req,
  input  logic                             res_ready,
  output logic                             res_valid,
  output cqsr_pkg::res_t                   res
);

  cqsr_pkg::state_t state, state_next;
  logic [cqsr_pkg::CAP_W-1:0] cap;
  logic [cqsr_pkg::PTR_W-1:0] head, head_next;
  logic [cqsr_pkg::PTR_W-1:0] tail, tail_next;
  logic [cqsr_pkg::CAP_W-1:0] cnt, cnt_next;
  cqsr_pkg::func_t            op;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] val;
  logic [cqsr_pkg::PTR_W-1:0] rp, rp_next;
  logic [cqsr_pkg::PTR_W-1:0] dp, dp_next;
  logic [cqsr_pkg::PTR_W-1:0] wp, wp_next;
  logic [cqsr_pkg::CAP_W-1:0] rem, rem_next;
  logic                       dvalid, dvalid_next;
  logic                       issuing, issuing_next;
  logic                       status, status_next;
  logic                       found, found_next;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] popped, popped_next;
  logic [cqsr_pkg::CAP_W-1:0] cap_new;
  logic                       match;

  assign req.ready = (state == cqsr_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign cap_new   = cqsr_pkg::cap_clamp(cfg.data);
  // shared compare: entry in flight against the searched value
  assign match     = dvalid && (rdata == val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cqsr_pkg::ST_IDLE;
      cap     <= cqsr_pkg::CAP_RESET;
      head    <= '0;
      tail    <= cqsr_pkg::PTR_W'(cqsr_pkg::CAP_RESET - cqsr_pkg::CAP_W'(1));
      cnt     <= '0;
      dvalid  <= 1'b0;
      issuing <= 1'b0;
    end else begin
      state   <= state_next;
      dvalid  <= dvalid_next;
      issuing <= issuing_next;
      if (cfg.valid && cfg.ready) begin
        cap  <= cap_new;
        head <= '0;
        tail <= cqsr_pkg::PTR_W'(cap_new - cqsr_pkg::CAP_W'(1));
        cnt  <= '0;
      end else begin
        head <= head_next;
        tail <= tail_next;
        cnt  <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= cqsr_pkg::func_t'(req.func);
      val <= req.value;
    end
    rp     <= rp_next;
    dp     <= dp_next;
    wp     <= wp_next;
    rem    <= rem_next;
    status <= status_next;
    found  <= found_next;
    popped <= popped_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    rp_next       = rp;
    dp_next       = dp;
    wp_next       = wp;
    rem_next      = rem;
    dvalid_next   = 1'b0;
    issuing_next  = issuing;
    status_next   = status;
    found_next    = found;
    popped_next   = popped;
    ram_req.we    = 1'b0;
    ram_req.waddr = wp;
    ram_req.wdata = rdata;
    ram_req.raddr = head;
    res_valid     = 1'b0;

    unique case (state)
      cqsr_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = cqsr_pkg::ST_EXEC;
        end
      end
      cqsr_pkg::ST_EXEC: begin
        status_next = 1'b1;
        found_next  = 1'b0;
        popped_next = '0;
        unique case (op)
          cqsr_pkg::FUNC_PUSH: begin
            if ((cnt < cap) && (val != '0)) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = cqsr_pkg::ring_next(tail, cap);
              ram_req.wdata = val;
              tail_next     = cqsr_pkg::ring_next(tail, cap);
              cnt_next      = cnt + cqsr_pkg::CAP_W'(1);
              status_next   = 1'b0;
            end
            state_next = cqsr_pkg::ST_HEAD_RD;
          end
          cqsr_pkg::FUNC_POP: begin
            if (cnt != '0) begin
              head_next   = cqsr_pkg::ring_next(head, cap);
              cnt_next    = cnt - cqsr_pkg::CAP_W'(1);
              status_next = 1'b0;
              state_next  = cqsr_pkg::ST_POP_DATA;
            end else begin
              state_next = cqsr_pkg::ST_HEAD_RD;
            end
          end
          cqsr_pkg::FUNC_CONTAINS, cqsr_pkg::FUNC_REMOVE: begin
            if ((val != '0) && (cnt != '0)) begin
              rp_next    = head;
              rem_next   = cnt;
              state_next = cqsr_pkg::ST_SCAN;
            end else begin
              state_next = cqsr_pkg::ST_HEAD_RD;
            end
          end
          default: state_next = cqsr_pkg::ST_HEAD_RD;
        endcase
      end
      cqsr_pkg::ST_POP_DATA: begin
        popped_next = rdata;
        state_next  = cqsr_pkg::ST_FINISH;
      end
      cqsr_pkg::ST_SCAN: begin
        ram_req.raddr = rp;
        if (rem != '0) begin
          rp_next     = cqsr_pkg::ring_next(rp, cap);
          rem_next    = rem - cqsr_pkg::CAP_W'(1);
          dvalid_next = 1'b1;
          dp_next     = rp;
        end
        if (match) begin
          status_next = 1'b0;
          dvalid_next = 1'b0;
          if (op == cqsr_pkg::FUNC_CONTAINS) begin
            found_next = 1'b1;
            state_next = cqsr_pkg::ST_HEAD_RD;
          end else if (dp == tail) begin
            tail_next  = cqsr_pkg::ring_prev(tail, cap);
            cnt_next   = cnt - cqsr_pkg::CAP_W'(1);
            state_next = cqsr_pkg::ST_HEAD_RD;
          end else begin
            wp_next      = dp;
            rp_next      = cqsr_pkg::ring_next(dp, cap);
            issuing_next = 1'b1;
            state_next   = cqsr_pkg::ST_SHIFT;
          end
        end else if (rem == '0) begin
          state_next = cqsr_pkg::ST_HEAD_RD;
        end
      end
      cqsr_pkg::ST_SHIFT: begin
        ram_req.raddr = rp;
        if (issuing) begin
          dp_next      = rp;
          dvalid_next  = 1'b1;
          rp_next      = cqsr_pkg::ring_next(rp, cap);
          issuing_next = (rp != tail);
        end
        if (dvalid) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wp;
          ram_req.wdata = rdata;
          wp_next       = dp;
          if (dp == tail) begin
            tail_next    = cqsr_pkg::ring_prev(tail, cap);
            cnt_next     = cnt - cqsr_pkg::CAP_W'(1);
            dvalid_next  = 1'b0;
            issuing_next = 1'b0;
            state_next   = cqsr_pkg::ST_HEAD_RD;
          end
        end
      end
      cqsr_pkg::ST_HEAD_RD: begin
        state_next = cqsr_pkg::ST_FINISH;
      end
      cqsr_pkg::ST_FINISH: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = cqsr_pkg::ST_IDLE;
        end
      end
      default: state_next = cqsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res.status       = status;
    res.popped_value = popped;
    res.found        = found;
    res.count        = cnt;
    res.full_res     = (cnt == cap);
    res.head_value   = (cnt != '0) ? rdata : '0;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= cap)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state != cqsr_pkg::ST_IDLE && state != cqsr_pkg::ST_FINISH))
    else $error("slot write outside an operation");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == cqsr_pkg::ST_EXEC)
    else $error("accepted item did not start");

  a_cfg_empty: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (cnt == '0 && head == '0))
    else $error("capacity write did not empty the queue");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.found) |-> !res.status)
    else $error("found reported with failure");

endmodule

[design/circular_queue_search_remove.sv]
// Ring-buffer queue of nonzero values with push, pop, contains and ordered
// remove. One operation is taken at a time: req is ready only while the
// sequencer is idle, and each transfer on req yields exactly one transfer on
// rsp carrying status, popped value, found flag, count, full flag and head
// value after the operation. Contains and remove walk the entries one per
// cycle through the single slot memory read port and one shared comparator.
// The walk stops at a match; a remove that must then close a gap moves each
// entry behind the match one slot toward the head, one per cycle. A finished
// result waits in an output register, so the next operation may start before
// rsp is taken; the sequencer holds its last state only while that register
// is still full.
// The capacity write on cfg is always ready and empties the queue; write it
// only while no operation is in flight. A capacity of zero acts as one, and
// values above the depth act as the depth. Slots need no clearing after
// reset, since only data read from slots holding entries is ever used.
module circular_queue_search_remove (
  input  logic       clk,
  input  logic       rst,
  cqsr_req_if.sink   req,
  cqsr_rsp_if.source rsp,
  cqsr_cfg_if.sink   cfg
);

  cqsr_pkg::ram_req_t               ram_req;
  logic [cqsr_pkg::VALUE_WIDTH-1:0] rdata;
  cqsr_pkg::res_t                   res;
  cqsr_pkg::res_t                   res_q;
  logic                             res_valid;
  logic                             res_ready;
  logic                             out_valid;

  // slot storage, one write and one registered read per cycle
  cqsr_ram #(
    .WIDTH(cqsr_pkg::VALUE_WIDTH),
    .DEPTH(cqsr_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(rdata)
  );

  // sequencer: pointers, capacity, search and gap-closing walk
  cqsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .rdata    (rdata),
    .ram_req  (ram_req),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  // the output register may take a new result when empty or being drained
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until the transfer completes
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = res_q.status;
  assign rsp.popped_value = res_q.popped_value;
  assign rsp.found        = res_q.found;
  assign rsp.count        = res_q.count;
  assign rsp.full_res     = res_q.full_res;
  assign rsp.head_value   = res_q.head_value;

endmodule
